[sv/tq_pkg.sv]
// ----------------------------------------------------------------------------
// Ticket queue package
// Shared types and constants for the two-class ticket queue arbiter.
// ----------------------------------------------------------------------------
package tq_pkg;

    localparam int unsigned NUM_W = 16;
    localparam int unsigned MIN_W = 11;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic [MIN_W-1:0] minute;
    } t_entry;

    typedef enum logic [2:0] {
        K_ISSUE  = 3'd0,
        K_SERVE  = 3'd1,
        K_PEEK   = 3'd2,
        K_FIND   = 3'd3,
        K_CANCEL = 3'd4
    } t_kind;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Per-cell command from the controller.
    typedef struct packed {
        logic             push;
        logic             shift;
        logic             match_en;
        logic [NUM_W-1:0] key;
        t_entry           data;
    } t_qcmd;

endpackage

[sv/two_class_ticket_queue_arbiter.sv]
// ----------------------------------------------------------------------------
// Two-class ticket queue arbiter
// Two cell-chain FIFOs served by weighted round robin, with find and cancel.
// ----------------------------------------------------------------------------
// Each input word passes through capture (S_IDLE), match (S_MATCH) and update
// (S_DONE), where the result word is registered, before the next is taken;
// input stays stalled for as long as a raised result word is stalled.
// Each queue is a chain of cells that compare and shift in parallel.
// Reset clears counts, served counts and streak, sets both next numbers to 1
// and the burst to 2; stored entries are not reset.
module two_class_ticket_queue_arbiter #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic        i_queue_select,
    input  logic [15:0] i_ticket_number,
    input  logic [10:0] i_arrival_minute,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_ticket_class,
    output logic [15:0] o_reported_number,
    output logic [10:0] o_reported_arrival,
    output logic [6:0]  o_queue_position,
    output logic [6:0]  o_normal_waiting,
    output logic [6:0]  o_preferred_waiting,
    output logic [15:0] o_normal_served,
    output logic [15:0] o_preferred_served
);
    import tq_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state       r_state;
    logic [2:0]   r_kind;
    logic         r_sel;
    logic [15:0]  r_key;
    logic [10:0]  r_min;
    logic [3:0]   r_burst;
    logic [3:0]   r_streak;
    logic [CW-1:0] r_cnt [2];
    logic [15:0]  r_next [2];
    logic [15:0]  r_served [2];
    logic         r_found;
    logic [CW-1:0] r_pos;
    t_entry       r_hit;

    t_qcmd        w_cmd [2];
    t_entry       w_head [2];
    t_entry       w_hent [2];
    logic         w_found [2];
    logic [CW-1:0] w_hpos [2];

    logic w_n, w_p, w_any, w_pick;
    assign w_n    = r_cnt[0] != '0;
    assign w_p    = r_cnt[1] != '0;
    assign w_any  = w_n || w_p;
    assign w_pick = (w_n && w_p) ? (r_streak >= r_burst) : !w_n;

    always_comb begin
        for (int q = 0; q < 2; q++) begin
            w_cmd[q].key      = r_key;
            w_cmd[q].data     = '{number: r_next[q], minute: r_min};
            w_cmd[q].match_en = (r_state == S_MATCH) && (r_sel == q[0]);
            w_cmd[q].push     = 1'b0;
            w_cmd[q].shift    = 1'b0;
        end
    end

    // Update command, issued in S_DONE on entry (one cycle).
    logic r_upd;
    t_qcmd w_ucmd [2];
    always_comb begin
        for (int q = 0; q < 2; q++) begin
            w_ucmd[q] = w_cmd[q];
            w_ucmd[q].match_en = (r_state == S_MATCH) && (r_sel == q[0]);
            if (r_upd) begin
                case (r_kind)
                    K_ISSUE: begin
                        w_ucmd[q].push = (r_sel == q[0]) && (r_cnt[q] < CW'(QUEUE_DEPTH));
                    end
                    K_SERVE: begin
                        w_ucmd[q].shift = w_any && (w_pick == q[0]);
                    end
                    K_CANCEL: begin
                        w_ucmd[q].shift = r_found && (r_sel == q[0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    for (genvar q = 0; q < 2; q++) begin : g_q
        tq_chain #(.DEPTH(QUEUE_DEPTH), .CW(CW)) u_chain (
            .i_clk       (i_clk),
            .i_count     (r_cnt[q]),
            .i_cmd       (w_ucmd[q]),
            .i_kill_pos  ((r_kind == K_CANCEL) ? r_pos : '0),
            .o_head      (w_head[q]),
            .o_hit_entry (w_hent[q]),
            .o_found     (w_found[q]),
            .o_hit_pos   (w_hpos[q])
        );
    end

    logic r_ovalid;
    assign o_stall = (r_state != S_IDLE) || r_ovalid && i_stall;
    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_burst    <= 4'd2;
            r_streak   <= '0;
            r_cnt[0]   <= '0;
            r_cnt[1]   <= '0;
            r_next[0]  <= 16'd1;
            r_next[1]  <= 16'd1;
            r_served[0] <= '0;
            r_served[1] <= '0;
            r_ovalid   <= 1'b0;
            r_upd      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_burst <= i_cfg_data;
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            r_upd <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_kind  <= i_kind;
                        r_sel   <= i_queue_select;
                        r_key   <= i_ticket_number;
                        r_min   <= i_arrival_minute;
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_found <= w_found[r_sel];
                    r_pos   <= w_hpos[r_sel];
                    r_hit   <= w_hent[r_sel];
                    r_upd   <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_ovalid           <= 1'b1;
                    o_status           <= ST_NONE;
                    o_ticket_class     <= 1'b0;
                    o_reported_number  <= '0;
                    o_reported_arrival <= '0;
                    o_queue_position   <= '0;
                    case (r_kind)
                        K_ISSUE: begin
                            o_ticket_class <= r_sel;
                            if (r_cnt[r_sel] >= CW'(QUEUE_DEPTH)) begin
                                o_status <= ST_FULL;
                            end else begin
                                o_status           <= ST_OK;
                                o_reported_number  <= r_next[r_sel];
                                o_reported_arrival <= r_min;
                                r_cnt[r_sel]       <= r_cnt[r_sel] + 1'b1;
                                r_next[r_sel]      <= (r_next[r_sel] == 16'hFFFF) ? 16'd1
                                                      : r_next[r_sel] + 16'd1;
                            end
                        end
                        K_SERVE, K_PEEK: begin
                            if (w_any) begin
                                o_status           <= ST_OK;
                                o_ticket_class     <= w_pick;
                                o_reported_number  <= w_head[w_pick].number;
                                o_reported_arrival <= w_head[w_pick].minute;
                                if (r_kind == K_SERVE) begin
                                    if (w_n && w_p) begin
                                        r_streak <= w_pick ? 4'd0 : r_streak + 4'd1;
                                    end
                                    r_cnt[w_pick] <= r_cnt[w_pick] - 1'b1;
                                    if (r_served[w_pick] != 16'hFFFF) begin
                                        r_served[w_pick] <= r_served[w_pick] + 16'd1;
                                    end
                                end
                            end
                        end
                        K_FIND, K_CANCEL: begin
                            o_ticket_class <= r_sel;
                            if (r_found) begin
                                o_status           <= ST_OK;
                                o_reported_number  <= r_hit.number;
                                o_reported_arrival <= r_hit.minute;
                                if (r_kind == K_FIND) begin
                                    o_queue_position <= 7'(r_pos) + 7'd1;
                                end else begin
                                    r_cnt[r_sel] <= r_cnt[r_sel] - 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_normal_waiting    = 7'(r_cnt[0]);
    assign o_preferred_waiting = 7'(r_cnt[1]);
    assign o_normal_served     = r_served[0];
    assign o_preferred_served  = r_served[1];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CW'(QUEUE_DEPTH) && r_cnt[1] <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_one_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_ovalid)
        else $error("result word not raised");
    a_next_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next[0] != 16'd0 && r_next[1] != 16'd0)
        else $error("ticket number zero");
`endif

endmodule

[sv/tq_cell.sv]
// ----------------------------------------------------------------------------
// Ticket queue cell
// Holds one queue entry, loaded by a push at the tail; compares it against a
// key and shifts from its right neighbor when a removal passes through it.
// ----------------------------------------------------------------------------
module tq_cell (
    input  logic             i_clk,
    input  logic             i_occ,
    input  logic             i_is_tail,
    input  tq_pkg::t_qcmd    i_cmd,
    input  logic             i_kill,
    input  tq_pkg::t_entry   i_right,
    output tq_pkg::t_entry   o_entry,
    output logic             o_hit
);
    import tq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.push && i_is_tail) begin
            n_entry = i_cmd.data;
        end else if (i_cmd.shift && i_kill) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_hit   = i_cmd.match_en && i_occ && (r_entry.number == i_cmd.key);

endmodule

[sv/tq_chain.sv]
// ----------------------------------------------------------------------------
// Ticket queue chain
// A row of cells forming one FIFO with find and mid-queue removal.
// ----------------------------------------------------------------------------
module tq_chain #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned CW    = 7
) (
    input  logic             i_clk,
    input  logic [CW-1:0]    i_count,
    input  tq_pkg::t_qcmd    i_cmd,
    input  logic [CW-1:0]    i_kill_pos,
    output tq_pkg::t_entry   o_head,
    output tq_pkg::t_entry   o_hit_entry,
    output logic             o_found,
    output logic [CW-1:0]    o_hit_pos
);
    import tq_pkg::*;

    t_entry             w_entry [DEPTH];
    logic [DEPTH-1:0]   w_hit;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_right;
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end
        tq_cell u_cell (
            .i_clk     (i_clk),
            .i_occ     (CW'(g) < i_count),
            .i_is_tail (CW'(g) == i_count),
            .i_cmd     (i_cmd),
            .i_kill    (CW'(g) >= i_kill_pos),
            .i_right   (w_right),
            .o_entry   (w_entry[g]),
            .o_hit     (w_hit[g])
        );
    end

    always_comb begin
        o_found     = 1'b0;
        o_hit_pos   = '0;
        o_hit_entry = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                o_found     = 1'b1;
                o_hit_pos   = CW'(i);
                o_hit_entry = w_entry[i];
            end
        end
    end

    assign o_head = w_entry[0];

endmodule
